### design/ubfr_pkg.sv
package ubfr_pkg;

   localparam int AddrWidthDefault = 32;

   localparam int CsrAddrWidth = 4;

   localparam logic [CsrAddrWidth-1:0] CSR_TIMEOUT  = 4'h0;
   localparam logic [CsrAddrWidth-1:0] CSR_MAX_SIZE = 4'h4;
   localparam logic [CsrAddrWidth-1:0] CSR_LOAD     = 4'h8;

   localparam logic [7:0]  TIMEOUT_RESET  = 8'd0;
   localparam logic [31:0] MAX_SIZE_RESET = 32'd1048576;
   localparam logic [31:0] LOAD_RESET     = 32'd0;

   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_BYTE  = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;

   localparam logic [3:0] PH_IDLE     = 4'd0;
   localparam logic [3:0] PH_PREFIX   = 4'd1;
   localparam logic [3:0] PH_PROBEHDR = 4'd2;
   localparam logic [3:0] PH_SIZE     = 4'd3;
   localparam logic [3:0] PH_PAYLOAD  = 4'd4;
   localparam logic [3:0] PH_OK       = 4'd5;
   localparam logic [3:0] PH_BAD      = 4'd6;
   localparam logic [3:0] PH_BIG      = 4'd7;
   localparam logic [3:0] PH_CSUM     = 4'd8;
   localparam logic [3:0] PH_TIMEOUT  = 4'd9;

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_RECEIVING = 3'd1;
   localparam logic [2:0] ST_SUCCESS   = 3'd2;
   localparam logic [2:0] ST_BAD_TYPE  = 3'd3;
   localparam logic [2:0] ST_TOO_LARGE = 3'd4;
   localparam logic [2:0] ST_CHECKSUM  = 3'd5;
   localparam logic [2:0] ST_TIMEOUT   = 3'd6;

   localparam logic [31:0] PROBE_WORD      = 32'h4F4C4548;
   localparam logic [15:0] IMAGE_TYPE_OK   = 16'h00c2;
   localparam logic [7:0]  DEFAULT_TIMEOUT = 8'd60;

   typedef struct packed {
      logic [7:0]  timeout_seconds;
      logic [31:0] max_image_size;
      logic [31:0] load_base;
   } cfg_type;

   typedef struct packed {
      logic        mem_write;
      logic [31:0] mem_addr;
      logic [7:0]  mem_data;
      logic        send_ack;
      logic [2:0]  status;
      logic [15:0] running_sum;
   } rsp_type;

   function automatic logic [2:0] status_of(input logic [3:0] ph);
      logic [2:0] st;
      case (ph)
         PH_PREFIX, PH_PROBEHDR, PH_SIZE, PH_PAYLOAD: st = ST_RECEIVING;
         PH_OK:      st = ST_SUCCESS;
         PH_BAD:     st = ST_BAD_TYPE;
         PH_BIG:     st = ST_TOO_LARGE;
         PH_CSUM:    st = ST_CHECKSUM;
         PH_TIMEOUT: st = ST_TIMEOUT;
         default:    st = ST_IDLE;
      endcase
      return st;
   endfunction

endpackage

### design/ubfr_csr.sv
module ubfr_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [ubfr_pkg::CsrAddrWidth-1:0]   paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready,
   output ubfr_pkg::cfg_type                   cfg
);
   import ubfr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (paddr)
            CSR_TIMEOUT:  cfg_in.timeout_seconds = pwdata[7:0];
            CSR_MAX_SIZE: cfg_in.max_image_size  = pwdata;
            CSR_LOAD:     cfg_in.load_base       = pwdata;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr)
         CSR_TIMEOUT:  prdata = {24'd0, cfg_ff.timeout_seconds};
         CSR_MAX_SIZE: prdata = cfg_ff.max_image_size;
         CSR_LOAD:     prdata = cfg_ff.load_base;
         default:      prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_seconds <= TIMEOUT_RESET;
         cfg_ff.max_image_size  <= MAX_SIZE_RESET;
         cfg_ff.load_base       <= LOAD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### design/ubfr_core.sv
module ubfr_core #(
   parameter int ADDR_WIDTH = ubfr_pkg::AddrWidthDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [1:0]        cmd,
   input  logic [7:0]        rx_byte,
   input  ubfr_pkg::cfg_type cfg,
   output ubfr_pkg::rsp_type rsp
);
   import ubfr_pkg::*;

   logic [3:0]  phase_ff, phase_in;
   logic [1:0]  hdr_idx_ff, hdr_idx_in;
   logic [23:0] prefix_ff, prefix_in;
   logic [15:0] exp_sum_ff, exp_sum_in;
   logic [15:0] img_type_ff, img_type_in;
   logic [31:0] img_size_ff, img_size_in;
   logic [31:0] rcvd_ff, rcvd_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  ticks_ff, ticks_in;

   logic                  receiving;
   logic [31:0]           full_word;
   logic [7:0]            limit;
   logic [ADDR_WIDTH-1:0] addr_sum;

   assign receiving = (phase_ff >= PH_PREFIX) && (phase_ff <= PH_PAYLOAD);
   assign full_word = {rx_byte, prefix_ff};
   assign limit     = (cfg.timeout_seconds != 8'd0) ? cfg.timeout_seconds : DEFAULT_TIMEOUT;
   assign addr_sum  = ADDR_WIDTH'(cfg.load_base) + ADDR_WIDTH'(rcvd_ff);

   always_comb begin
      phase_in    = phase_ff;
      hdr_idx_in  = hdr_idx_ff;
      prefix_in   = prefix_ff;
      exp_sum_in  = exp_sum_ff;
      img_type_in = img_type_ff;
      img_size_in = img_size_ff;
      rcvd_in     = rcvd_ff;
      sum_in      = sum_ff;
      ticks_in    = ticks_ff;

      rsp           = '0;

      case (cmd)
         CMD_START: begin
            phase_in    = PH_PREFIX;
            hdr_idx_in  = 2'd0;
            prefix_in   = 24'd0;
            exp_sum_in  = 16'd0;
            img_type_in = 16'd0;
            img_size_in = 32'd0;
            rcvd_in     = 32'd0;
            sum_in      = 16'd0;
            ticks_in    = 8'd0;
         end
         CMD_BYTE: begin
            if (receiving) begin
               ticks_in   = 8'd0;
               hdr_idx_in = hdr_idx_ff + 2'd1;
               case (phase_ff)
                  PH_PREFIX: begin
                     case (hdr_idx_ff)
                        2'd0:    prefix_in[7:0]   = rx_byte;
                        2'd1:    prefix_in[15:8]  = rx_byte;
                        2'd2:    prefix_in[23:16] = rx_byte;
                        default: prefix_in        = prefix_ff;
                     endcase
                     if (hdr_idx_ff == 2'd3) begin
                        if (full_word == PROBE_WORD) begin
                           rsp.send_ack = 1'b1;
                           exp_sum_in   = 16'd0;
                           img_type_in  = 16'd0;
                           phase_in     = PH_PROBEHDR;
                        end else begin
                           exp_sum_in  = full_word[15:0];
                           img_type_in = full_word[31:16];
                           phase_in    = PH_SIZE;
                        end
                     end
                  end
                  PH_PROBEHDR: begin
                     case (hdr_idx_ff)
                        2'd0:    exp_sum_in[7:0]   = rx_byte;
                        2'd1:    exp_sum_in[15:8]  = rx_byte;
                        2'd2:    img_type_in[7:0]  = rx_byte;
                        default: img_type_in[15:8] = rx_byte;
                     endcase
                     if (hdr_idx_ff == 2'd3) begin
                        phase_in = PH_SIZE;
                     end
                  end
                  PH_SIZE: begin
                     case (hdr_idx_ff)
                        2'd0:    img_size_in[7:0]   = rx_byte;
                        2'd1:    img_size_in[15:8]  = rx_byte;
                        2'd2:    img_size_in[23:16] = rx_byte;
                        default: img_size_in[31:24] = rx_byte;
                     endcase
                     if (hdr_idx_ff == 2'd3) begin
                        if (img_type_ff != IMAGE_TYPE_OK || img_size_in == 32'd0) begin
                           phase_in = PH_BAD;
                        end else if (img_size_in > cfg.max_image_size) begin
                           phase_in = PH_BIG;
                        end else begin
                           phase_in = PH_PAYLOAD;
                        end
                     end
                  end
                  default: begin
                     hdr_idx_in    = hdr_idx_ff;
                     rsp.mem_write = 1'b1;
                     rsp.mem_addr  = 32'(addr_sum);
                     rsp.mem_data  = rx_byte;
                     sum_in        = sum_ff + {8'd0, rx_byte};
                     rcvd_in       = rcvd_ff + 32'd1;
                     if (rcvd_in >= img_size_ff) begin
                        phase_in = (sum_in == exp_sum_ff) ? PH_OK : PH_CSUM;
                     end
                  end
               endcase
            end
         end
         CMD_TICK: begin
            if (receiving) begin
               ticks_in = ticks_ff + 8'd1;
               if (ticks_in >= limit) begin
                  phase_in = PH_TIMEOUT;
               end
            end
         end
         default: phase_in = phase_ff;
      endcase

      rsp.status      = status_of(phase_in);
      rsp.running_sum = sum_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         hdr_idx_ff  <= 2'd0;
         prefix_ff   <= 24'd0;
         exp_sum_ff  <= 16'd0;
         img_type_ff <= 16'd0;
         img_size_ff <= 32'd0;
         rcvd_ff     <= 32'd0;
         sum_ff      <= 16'd0;
         ticks_ff    <= 8'd0;
      end else if (step) begin
         phase_ff    <= phase_in;
         hdr_idx_ff  <= hdr_idx_in;
         prefix_ff   <= prefix_in;
         exp_sum_ff  <= exp_sum_in;
         img_type_ff <= img_type_in;
         img_size_ff <= img_size_in;
         rcvd_ff     <= rcvd_in;
         sum_ff      <= sum_in;
         ticks_ff    <= ticks_in;
      end
   end

endmodule

### design/uart_boot_frame_receiver.sv
// Boot image frame receiver. One item (start, received byte or one-second tick)
// is taken per clock while rsp_ready does not hold back the result, and gives
// exactly one result item, carrying the memory write for a payload byte, the
// acknowledge request after the probe word, the status and the running 16-bit
// payload sum. Each item passes an input register and then, once the result
// register is free or being taken, the core state and the result register; a
// stalled result holds back the next item. The configuration registers are
// written through the APB port at byte addresses 0 (timeout_seconds), 4
// (max_image_size) and 8 (load_base), and are meant to change only while no item
// is in flight.
module uart_boot_frame_receiver #(
   parameter int ADDR_WIDTH = ubfr_pkg::AddrWidthDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_cmd,
   input  logic [7:0]                        req_rx_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_mem_write,
   output logic [31:0]                       rsp_mem_addr,
   output logic [7:0]                        rsp_mem_data,
   output logic                              rsp_send_ack,
   output logic [2:0]                        rsp_status,
   output logic [15:0]                       rsp_running_sum,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [ubfr_pkg::CsrAddrWidth-1:0] paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);
   import ubfr_pkg::*;

   cfg_type    cfg;
   rsp_type    rsp_next;
   rsp_type    rsp_ff;
   logic       in_valid_ff;
   logic [1:0] in_cmd_ff;
   logic [7:0] in_byte_ff;
   logic       rsp_valid_ff;
   logic       advance;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   ubfr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ubfr_core #(
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .cmd     (in_cmd_ff),
      .rx_byte (in_byte_ff),
      .cfg     (cfg),
      .rsp     (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_cmd_ff  <= req_cmd;
         in_byte_ff <= req_rx_byte;
      end
      if (advance) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_mem_write   = rsp_ff.mem_write;
   assign rsp_mem_addr    = rsp_ff.mem_addr;
   assign rsp_mem_data    = rsp_ff.mem_data;
   assign rsp_send_ack    = rsp_ff.send_ack;
   assign rsp_status      = rsp_ff.status;
   assign rsp_running_sum = rsp_ff.running_sum;

endmodule

### design/ubfr_checker.sv
module ubfr_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_mem_write,
   input logic [31:0] rsp_mem_addr,
   input logic [7:0]  rsp_mem_data,
   input logic        rsp_send_ack,
   input logic [2:0]  rsp_status,
   input logic [15:0] rsp_running_sum
);
   import ubfr_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_running_sum) && $stable(rsp_mem_addr))
      else $error("result changed while stalled");

   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_mem_write |-> rsp_mem_addr == 32'd0 && rsp_mem_data == 8'd0)
      else $error("address or data set without a write");

   a_ack_receiving: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_send_ack |-> rsp_status == ST_RECEIVING && !rsp_mem_write)
      else $error("acknowledge outside the probe");

   a_write_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mem_write |-> rsp_status == ST_RECEIVING
         || rsp_status == ST_SUCCESS || rsp_status == ST_CHECKSUM)
      else $error("payload write with a header status");

   a_idle_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_IDLE |-> rsp_running_sum == 16'd0 && !rsp_mem_write)
      else $error("activity while idle");

endmodule

bind uart_boot_frame_receiver ubfr_checker u_ubfr_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_mem_write   (rsp_mem_write),
   .rsp_mem_addr    (rsp_mem_addr),
   .rsp_mem_data    (rsp_mem_data),
   .rsp_send_ack    (rsp_send_ack),
   .rsp_status      (rsp_status),
   .rsp_running_sum (rsp_running_sum)
);
